// ===== rtl/limit_alarm_bank_with_snooze_unit_macros.svh =====
// Assertion macros for the limit alarm bank.
// Expects signals clk and arst_n in the including module; no other dependencies.
`ifndef LIMIT_ALARM_BANK_WITH_SNOOZE_UNIT_MACROS_SVH
`define LIMIT_ALARM_BANK_WITH_SNOOZE_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define LABS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset
`define LABS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/labs_pkg.sv =====
// Shared types and constants for the limit alarm bank.
// No dependencies.
package labs_pkg;

	// Default number of alarm channels
	localparam int NUM_CHANNELS_DEF = 8;

	// Field widths fixed by the item format
	localparam int CHAN_W  = 3;
	localparam int VALUE_W = 32;
	localparam int HYST_W  = 16;

	// Request codes
	typedef enum logic [1:0] {
		REQ_SAMPLE = 2'd0,
		REQ_TICK   = 2'd1,
		REQ_SNOOZE = 2'd2,
		REQ_DEFINE = 2'd3
	} req_t;

	// Per-channel alarm mode
	typedef enum logic [1:0] {
		MODE_INACTIVE = 2'd0,
		MODE_ACTIVE   = 2'd1,
		MODE_SNOOZED  = 2'd2
	} mode_t;

endpackage

// ===== rtl/labs_cfg_if.sv =====
// Configuration write channel for the limit alarm bank.
// Depends on labs_pkg.
interface labs_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [labs_pkg::HYST_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/labs_req_if.sv =====
// Request item channel for the limit alarm bank.
// Depends on labs_pkg.
interface labs_req_if;
	logic                                valid;
	logic                                ready;
	labs_pkg::req_t                      req_type;
	logic [labs_pkg::CHAN_W-1:0]         channel;
	logic signed [labs_pkg::VALUE_W-1:0] sample_value;
	logic                                sample_valid;
	logic                                alarm_enable;
	logic signed [labs_pkg::VALUE_W-1:0] high_limit;
	logic signed [labs_pkg::VALUE_W-1:0] low_limit;
	logic [labs_pkg::VALUE_W-1:0]        snooze_ms;

	modport source (output valid, output req_type, output channel, output sample_value,
		output sample_valid, output alarm_enable, output high_limit, output low_limit,
		output snooze_ms, input ready);
	modport sink (input valid, input req_type, input channel, input sample_value,
		input sample_valid, input alarm_enable, input high_limit, input low_limit,
		input snooze_ms, output ready);
endinterface

// ===== rtl/labs_rsp_if.sv =====
// Result item channel for the limit alarm bank.
// Depends on labs_pkg.
interface labs_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  channel_state;
	logic                        accepted;
	logic [3:0]                  active_count;
	logic                        any_active;
	logic [labs_pkg::CHAN_W-1:0] first_active;

	modport source (output valid, output channel_state, output accepted,
		output active_count, output any_active, output first_active, input ready);
	modport sink (input valid, input channel_state, input accepted,
		input active_count, input any_active, input first_active, output ready);
endinterface

// ===== rtl/limit_alarm_bank_with_snooze_unit.sv =====
// Limit alarm bank with snooze: top level.
// Depends on labs_pkg, labs_cfg_if, labs_req_if, labs_rsp_if and the macros header.
//
// Bank of NUM_CHANNELS high/low limit alarms on Q16.16 values with hysteresis on
// clearing and a millisecond snooze. Each request item (sample, tick, snooze,
// define) is captured in an input register, then in one pass it reads and updates
// the addressed channel's registers and loads the result register; one item is
// taken every cycle when the result side keeps up. The pass holds two 32x18
// multiplies for the hysteresis thresholds, which set the cycle time. The bank
// summary (active count, first active channel) is decoded from the channel
// registers, which always reflect every item up to the one in the result
// register. The hysteresis register is always ready and should be written only
// while the block is idle.
`include "limit_alarm_bank_with_snooze_unit_macros.svh"

module limit_alarm_bank_with_snooze_unit #(
	parameter int NUM_CHANNELS = labs_pkg::NUM_CHANNELS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	labs_cfg_if.sink   cfg,
	labs_req_if.sink   req,
	labs_rsp_if.source rsp
);

	localparam int CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int VW    = labs_pkg::VALUE_W;
	localparam int PW    = 50;
	localparam int CNT_W = $clog2(NUM_CHANNELS + 1);

	// Configuration register
	logic [labs_pkg::HYST_W-1:0] hyst_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hyst_q <= '0;
		end else if (cfg.valid) begin
			hyst_q <= cfg.data;
		end
	end

	// Input register stage
	logic                        valid_s1;
	labs_pkg::req_t              req_type_s1;
	logic [labs_pkg::CHAN_W-1:0] channel_s1;
	logic signed [VW-1:0]        sample_value_s1;
	logic                        sample_valid_s1;
	logic                        alarm_enable_s1;
	logic signed [VW-1:0]        high_limit_s1;
	logic signed [VW-1:0]        low_limit_s1;
	logic [VW-1:0]               snooze_ms_s1;

	logic rsp_valid_q;
	logic adv;

	assign adv       = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_type_s1     <= req.req_type;
			channel_s1      <= req.channel;
			sample_value_s1 <= req.sample_value;
			sample_valid_s1 <= req.sample_valid;
			alarm_enable_s1 <= req.alarm_enable;
			high_limit_s1   <= req.high_limit;
			low_limit_s1    <= req.low_limit;
			snooze_ms_s1    <= req.snooze_ms;
		end
	end

	// Channel registers
	logic [VW-1:0]                    time_q;
	logic [NUM_CHANNELS-1:0]          defined_q;
	logic [NUM_CHANNELS-1:0]          enabled_q;
	logic [NUM_CHANNELS-1:0][1:0]     mode_q;
	logic [NUM_CHANNELS-1:0][VW-1:0]  start_q;
	logic signed [VW-1:0]             high_q [NUM_CHANNELS];
	logic signed [VW-1:0]             low_q  [NUM_CHANNELS];
	logic [VW-1:0]                    len_q  [NUM_CHANNELS];

	// Addressed channel read
	logic [CH_W-1:0]      ch_idx;
	logic                 in_range;
	logic                 defined_cur;
	labs_pkg::mode_t      mode_cur;
	logic signed [VW-1:0] hi_r;
	logic signed [VW-1:0] lo_r;
	logic                 elapsed;

	assign ch_idx      = CH_W'(channel_s1);
	assign in_range    = int'(channel_s1) < NUM_CHANNELS;
	assign defined_cur = in_range && defined_q[ch_idx];
	assign mode_cur    = labs_pkg::mode_t'(mode_q[ch_idx]);
	assign hi_r        = high_q[ch_idx];
	assign lo_r        = low_q[ch_idx];
	assign elapsed     = (time_q - start_q[ch_idx]) > len_q[ch_idx];

	// Limit compare and hysteresis thresholds
	logic [16:0]          f_hi;
	logic [16:0]          f_lo;
	logic signed [17:0]   fs_hi;
	logic signed [17:0]   fs_lo;
	logic signed [PW-1:0] vs;
	logic signed [PW-1:0] hi_prod;
	logic signed [PW-1:0] lo_prod;
	logic                 hi_pos;
	logic                 lo_pos;
	logic                 fire;
	logic                 clear;

	assign f_hi    = 17'h10000 - {1'b0, hyst_q};
	assign f_lo    = 17'h10000 + {1'b0, hyst_q};
	assign fs_hi   = $signed({1'b0, f_hi});
	assign fs_lo   = $signed({1'b0, f_lo});
	assign vs      = $signed({{2{sample_value_s1[VW-1]}}, sample_value_s1, 16'h0000});
	assign hi_prod = PW'(hi_r) * PW'(fs_hi);
	assign lo_prod = PW'(lo_r) * PW'(fs_lo);
	assign hi_pos  = hi_r > 32'sd0;
	assign lo_pos  = lo_r > 32'sd0;
	assign fire    = (hi_pos && (sample_value_s1 > hi_r)) || (lo_pos && (sample_value_s1 < lo_r));
	assign clear   = (!hi_pos || (vs < hi_prod)) && (!lo_pos || (vs > lo_prod));

	// Clamped low limit for define
	logic signed [VW-1:0] def_lo;

	assign def_lo = ((high_limit_s1 > 32'sd0) && (low_limit_s1 > high_limit_s1)) ?
		high_limit_s1 : low_limit_s1;

	// Item decode: write enables and result fields
	logic            acc_d;
	logic            mode_we;
	labs_pkg::mode_t mode_wr;
	logic            def_we;
	logic            snz_we;
	logic            tick_d;
	labs_pkg::mode_t mode_after;
	logic [1:0]      state_d;

	always_comb begin
		acc_d   = 1'b1;
		mode_we = 1'b0;
		mode_wr = mode_cur;
		def_we  = 1'b0;
		snz_we  = 1'b0;
		tick_d  = 1'b0;
		case (req_type_s1)
			labs_pkg::REQ_SAMPLE: begin
				if (!defined_cur) begin
					acc_d = 1'b0;
				end else if (enabled_q[ch_idx] && sample_valid_s1) begin
					if (mode_cur == labs_pkg::MODE_INACTIVE ||
						(mode_cur == labs_pkg::MODE_SNOOZED && elapsed)) begin
						if (fire) begin
							mode_we = 1'b1;
							mode_wr = labs_pkg::MODE_ACTIVE;
						end
					end else if (mode_cur == labs_pkg::MODE_ACTIVE && clear) begin
						mode_we = 1'b1;
						mode_wr = labs_pkg::MODE_INACTIVE;
					end
				end
			end
			labs_pkg::REQ_TICK: begin
				tick_d = 1'b1;
			end
			labs_pkg::REQ_SNOOZE: begin
				if (!defined_cur) begin
					acc_d = 1'b0;
				end else begin
					snz_we  = 1'b1;
					mode_we = 1'b1;
					mode_wr = labs_pkg::MODE_SNOOZED;
				end
			end
			labs_pkg::REQ_DEFINE: begin
				if (!in_range) begin
					acc_d = 1'b0;
				end else begin
					def_we  = 1'b1;
					mode_we = 1'b1;
					mode_wr = labs_pkg::MODE_INACTIVE;
				end
			end
			default: begin
				acc_d = 1'b0;
			end
		endcase
		mode_after = mode_we ? mode_wr : mode_cur;
		state_d    = ((defined_cur || def_we) ? mode_after : labs_pkg::MODE_INACTIVE);
	end

	// Channel register update, once per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q    <= '0;
			defined_q <= '0;
			enabled_q <= '0;
			mode_q    <= '0;
			start_q   <= '0;
		end else if (adv) begin
			if (tick_d) begin
				time_q <= time_q + VW'(1);
			end
			if (mode_we) begin
				mode_q[ch_idx] <= mode_wr;
			end
			if (snz_we) begin
				start_q[ch_idx] <= time_q;
			end
			if (def_we) begin
				defined_q[ch_idx] <= 1'b1;
				enabled_q[ch_idx] <= alarm_enable_s1;
				start_q[ch_idx]   <= '0;
			end
		end
	end

	// Limit and snooze length storage, written only by define
	always_ff @(posedge clk) begin
		if (adv && def_we) begin
			high_q[ch_idx] <= high_limit_s1;
			low_q[ch_idx]  <= def_lo;
			len_q[ch_idx]  <= snooze_ms_s1;
		end
	end

	// Result register
	logic [1:0] state_q;
	logic       acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			state_q <= state_d;
			acc_q   <= acc_d;
		end
	end

	// Bank summary from the channel registers
	logic [NUM_CHANNELS-1:0] act;
	logic [CNT_W-1:0]        cnt;
	logic [5:0]              first;

	always_comb begin
		cnt   = '0;
		first = '0;
		for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
			act[i] = defined_q[i] && (mode_q[i] == labs_pkg::MODE_ACTIVE);
			cnt    = cnt + CNT_W'(act[i]);
			if (act[i]) begin
				first = 6'(i);
			end
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.channel_state = state_q;
	assign rsp.accepted      = acc_q;
	assign rsp.active_count  = (32'(cnt) > 15) ? 4'd15 : 4'(cnt);
	assign rsp.any_active    = |act;
	assign rsp.first_active  = first[labs_pkg::CHAN_W-1:0];

	// Checks
	`LABS_ASSERT_NEXT(a_adv_loads_rsp, adv, rsp_valid_q, "result register not loaded")
	`LABS_ASSERT_NEXT(a_reject_no_change, adv && !acc_d,
		$stable(mode_q) && $stable(defined_q), "rejected item changed channel state")
	`LABS_ASSERT_NEXT(a_tick_advances, adv && tick_d, time_q == $past(time_q) + VW'(1),
		"tick did not advance the clock")
	`LABS_ASSERT_NEXT(a_define_inactive, adv && def_we,
		defined_q[$past(ch_idx)] && mode_q[$past(ch_idx)] == labs_pkg::MODE_INACTIVE,
		"defined channel not left inactive")
	`LABS_ASSERT_NOW(a_summary_match, rsp_valid_q,
		rsp.any_active == (rsp.active_count != 4'd0), "active summary mismatch")

endmodule
